// ===== rtl/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// Plasma pixel generator package
// Shared constants, the table fill write request, and the constant tables
// that are worked out at elaboration from the Q14 sine approximation.
// ----------------------------------------------------------------------------
package ppg_pkg;

	// Both lookup memories are 256 x 256 entries, addressed as row * 256 + column.
	localparam int ADDR_W    = 16;
	localparam int ROM_DEPTH = 1 << ADDR_W;

	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        dist_byte;
		logic [7:0]        wave;
	} fill_wr_t;

	typedef logic [255:0][42:0] sq_tab_t;
	typedef logic [255:0][5:0]  shift_tab_t;

	// Q14 sine of a 16-bit fraction of a turn, folded to a quarter wave.
	function automatic logic signed [16:0] sine_q14(input logic [15:0] phase);
		logic [31:0] t;
		logic [31:0] z2;
		logic [31:0] u;
		logic [31:0] w;
		logic [31:0] mag;
		t   = phase[14] ? (32'd16384 - 32'(phase[13:0])) : 32'(phase[13:0]);
		z2  = (t * t) >> 14;
		u   = (z2 * 32'd1160) >> 14;
		w   = (z2 * (32'd10512 - u)) >> 14;
		mag = (t * (32'd25736 - w)) >> 14;
		return phase[15] ? -$signed(17'(mag)) : $signed(17'(mag));
	endfunction

	// Squared, scaled sine per table column or row, plus a fixed bias.
	function automatic sq_tab_t build_sq_tab(input logic [15:0] phase_add,
	                                         input logic [63:0] bias);
		sq_tab_t            tab;
		logic signed [16:0] s;
		logic [63:0]        m;
		for (int i = 0; i < 256; i++) begin
			s      = sine_q14(16'(i * 256) + phase_add);
			m      = 64'd150 * 64'(s < 0 ? -s : s);
			tab[i] = 43'(m * m + bias);
		end
		return tab;
	endfunction

	// Signed column shift, truncated toward zero, in -16..16.
	function automatic shift_tab_t build_shift_tab();
		shift_tab_t         tab;
		logic signed [16:0] s;
		logic [31:0]        m;
		for (int i = 0; i < 256; i++) begin
			s      = sine_q14(16'(i * 256));
			m      = (32'(s < 0 ? -s : s) * 32'd16) >> 14;
			tab[i] = (s < 0) ? 6'(-m) : 6'(m);
		end
		return tab;
	endfunction

	localparam sq_tab_t    SX_SQ     = build_sq_tab(16'd0, 64'd0);
	// The row table also carries the constant 16 << 28 under the square root.
	localparam sq_tab_t    CY_SQ     = build_sq_tab(16'd16384, 64'd1 << 32);
	localparam shift_tab_t SHIFT_TAB = build_shift_tab();

endpackage

// ===== rtl/plasma_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// Plasma pixel generator
// Sums four table bytes and a roll value per pixel and maps the sum through
// the selected render mode.
// ----------------------------------------------------------------------------
// Usage: pixel requests enter on the s_axis channel (column and row) and one
// result per request leaves on the m_axis channel, in order. Registers are
// written through the cfg channel, which is always ready; write them only
// while no pixel is in flight.
// After reset the distance and wave tables are computed into two internal
// memories, one entry per clock. While the fill runs, s_axis_tready stays
// low; configuration writes are still taken.
// Throughput is one pixel per clock unless the receiver stalls: the four table
// reads of a pixel go to two memories with two read ports each. The address,
// read, sum and mode stages register each request. When the receiver stalls,
// the pipeline keeps filling its empty stages and then holds; nothing is dropped.
// ----------------------------------------------------------------------------
module plasma_pixel_generator import ppg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [6:0] pixel_x, [13:7] pixel_y, [15:14] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] pixel_index, [14:8] source_column, [15] zero
	output logic        m_axis_tuser,  // [0] use_source
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	typedef enum logic [2:0] {
		REG_OFFSET_ONE   = 3'd0,
		REG_OFFSET_TWO   = 3'd1,
		REG_OFFSET_THREE = 3'd2,
		REG_OFFSET_FOUR  = 3'd3,
		REG_ROLL         = 3'd4,
		REG_KEY          = 3'd5,
		REG_MODE         = 3'd6
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_PLAIN    = 2'd0,
		MODE_KEY      = 2'd1,
		MODE_DISPLACE = 2'd2
	} mode_t;

	fill_wr_t fill_wr;
	logic     fill_done;

	logic [14:0] off_q [0:3];
	logic [7:0]  roll_q;
	logic [7:0]  key_q;
	logic [1:0]  mode_q;

	logic [15:0] mem_a [0:ROM_DEPTH-1];  // {distance, wave}
	logic [7:0]  mem_b [0:ROM_DEPTH-1];  // wave

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic              en1, en2, en3, en4;
	logic [ADDR_W-1:0] addr_s1 [0:3];
	logic [6:0]        px_s1, px_s2, px_s3;
	logic [7:0]        dist_s2, w2_s2, w3_s2, w4_s2;
	logic [7:0]        sum_s3;
	logic [7:0]        idx_s4;
	logic [6:0]        col_s4;
	logic              use_s4;

	logic [ADDR_W-1:0] base;
	logic [7:0]        idx_c;
	logic [6:0]        col_c;
	logic              use_c;
	logic [5:0]        shift_c;

	ppg_table_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fill_wr),
		.done   (fill_done)
	);

	// A stage moves when it is empty or the stage after it moves.
	assign en4 = !vld_s4 || m_axis_tready;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign s_axis_tready = fill_done && en1;
	assign cfg_ready     = 1'b1;

	assign base = {1'b0, s_axis_tdata[13:7], 1'b0, s_axis_tdata[6:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) off_q[k] <= '0;
			roll_q <= '0;
			key_q  <= '0;
			mode_q <= MODE_PLAIN;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_OFFSET_ONE:   off_q[0] <= cfg_data;
					REG_OFFSET_TWO:   off_q[1] <= cfg_data;
					REG_OFFSET_THREE: off_q[2] <= cfg_data;
					REG_OFFSET_FOUR:  off_q[3] <= cfg_data;
					REG_ROLL:         roll_q   <= cfg_data[7:0];
					REG_KEY:          key_q    <= cfg_data[7:0];
					REG_MODE:         mode_q   <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (en1) vld_s1 <= s_axis_tvalid && s_axis_tready;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < 4; k++) addr_s1[k] <= base + ADDR_W'(off_q[k]);
			px_s1 <= s_axis_tdata[6:0];
		end
		if (en2) px_s2 <= px_s1;
		if (en3) begin
			sum_s3 <= 8'(roll_q + dist_s2 + w2_s2 + w3_s2 + w4_s2);
			px_s3  <= px_s2;
		end
		if (en4) begin
			idx_s4 <= idx_c;
			col_s4 <= col_c;
			use_s4 <= use_c;
		end
	end

	// Table memories: written only by the fill, read at two ports each.
	always_ff @(posedge clk) begin
		if (fill_wr.vld) begin
			mem_a[fill_wr.addr] <= {fill_wr.dist_byte, fill_wr.wave};
			mem_b[fill_wr.addr] <= fill_wr.wave;
		end
		if (en2) begin
			dist_s2 <= mem_a[addr_s1[0]][15:8];
			w2_s2   <= mem_a[addr_s1[1]][7:0];
			w3_s2   <= mem_b[addr_s1[2]];
			w4_s2   <= mem_b[addr_s1[3]];
		end
	end

	assign shift_c = SHIFT_TAB[sum_s3];

	always_comb begin
		idx_c = sum_s3;
		col_c = '0;
		use_c = 1'b0;
		case (mode_q)
			MODE_DISPLACE: begin
				// Adding the frame width before the wrap drops out modulo 128.
				idx_c = '0;
				col_c = px_s3 + {shift_c[5], shift_c};
				use_c = 1'b1;
			end
			MODE_KEY: begin
				// A key above 200 exceeds half the sum range, so one subtract
				// gives the remainder.
				if (key_q > 8'd200) begin
					idx_c = (sum_s3 >= key_q) ? (sum_s3 - key_q) : sum_s3;
				end else if (sum_s3 == key_q) begin
					idx_c = sum_s3 ^ 8'd1;
				end
			end
			default: idx_c = sum_s3;
		endcase
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {1'b0, col_s4, idx_s4};
	assign m_axis_tuser  = use_s4;

	a_fill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fill_wr.vld |-> !vld_s1 && !vld_s2 && !vld_s3 && !vld_s4)
		else $error("pixel in flight while tables are being filled");

	a_fill_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |=> fill_done)
		else $error("table fill done flag dropped");

	a_sum_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !en3 |=> vld_s3 && $stable(sum_s3))
		else $error("stalled sum stage lost its value");

	a_field_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser && m_axis_tdata[7:0] == 8'd0)
			|| (!m_axis_tuser && m_axis_tdata[14:8] == 7'd0))
		else $error("result carries fields of the wrong mode");

endmodule

// ===== rtl/ppg_table_fill.sv =====
// ----------------------------------------------------------------------------
// Plasma table fill
// After reset, computes every distance and wave entry, one per clock, through
// a square root, a reciprocal divide and a sine pipeline, and issues writes.
// ----------------------------------------------------------------------------
module ppg_table_fill import ppg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	output fill_wr_t wr,
	output logic     done
);

	localparam int          SQRT_STEPS = 22;
	localparam logic [24:0] RECIP      = 25'((64'd400000 << 28) / 64'd5969026);
	localparam logic [40:0] DIVISOR    = 41'd5969026;

	logic [ADDR_W:0] cnt_q;
	logic            done_q;
	logic            issue;

	logic [43:0]       sq_rem_s  [0:SQRT_STEPS];
	logic [44:0]       sq_res_s  [0:SQRT_STEPS];
	logic [ADDR_W-1:0] sq_addr_s [0:SQRT_STEPS];
	logic              sq_vld_s  [0:SQRT_STEPS];
	logic [44:0]       trial_c   [0:SQRT_STEPS-1];
	logic              take_c    [0:SQRT_STEPS-1];

	logic [ADDR_W-1:0] addr_s [2:11];
	logic              vld_s  [2:11];
	logic [7:0]        dist_s [3:11];
	logic              neg_s  [6:10];

	logic [21:0] d_s2;
	logic [46:0] pm_s3;
	logic [40:0] pn_s3;
	logic [17:0] qe_s4;
	logic [40:0] pq_s4;
	logic [40:0] pn_s4;
	logic [15:0] phase_s5;
	logic [14:0] t_s6;
	logic [14:0] t_s7;
	logic [14:0] z2_s7;
	logic [14:0] t_s8;
	logic [14:0] z2_s8;
	logic [10:0] u_s8;
	logic [14:0] t_s9;
	logic [13:0] w_s9;
	logic [14:0] mag_s10;
	logic [7:0]  wave_s11;

	logic [24:0] dist_c;
	logic [40:0] rem_c;
	logic [15:0] level_c;
	logic [21:0] wave_c;

	assign issue = !cnt_q[ADDR_W];

	always_comb begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			trial_c[k] = sq_res_s[k] + (45'd1 << (42 - 2 * k));
			take_c[k]  = {1'b0, sq_rem_s[k]} >= trial_c[k];
		end
	end

	assign dist_c  = 25'(d_s2) * 25'd5 + 25'd6554;
	assign rem_c   = pn_s4 - pq_s4;
	assign level_c = neg_s[10] ? (16'd16384 - 16'(mag_s10)) : (16'd16384 + 16'(mag_s10));
	assign wave_c  = 22'(level_c) * 22'd90 + 22'd6554;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			for (int k = 0; k <= SQRT_STEPS; k++) sq_vld_s[k] <= 1'b0;
			for (int k = 2; k <= 11; k++) vld_s[k] <= 1'b0;
		end else begin
			if (issue) cnt_q <= cnt_q + 1'b1;
			sq_vld_s[0] <= issue;
			for (int k = 0; k < SQRT_STEPS; k++) sq_vld_s[k+1] <= sq_vld_s[k];
			vld_s[2] <= sq_vld_s[SQRT_STEPS];
			for (int k = 3; k <= 11; k++) vld_s[k] <= vld_s[k-1];
			if (wr.vld && wr.addr == '1) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_s[0]  <= 44'(SX_SQ[cnt_q[7:0]]) + 44'(CY_SQ[cnt_q[15:8]]);
		sq_res_s[0]  <= '0;
		sq_addr_s[0] <= cnt_q[ADDR_W-1:0];
		for (int k = 0; k < SQRT_STEPS; k++) begin
			sq_addr_s[k+1] <= sq_addr_s[k];
			if (take_c[k]) begin
				sq_rem_s[k+1] <= 44'({1'b0, sq_rem_s[k]} - trial_c[k]);
				sq_res_s[k+1] <= (sq_res_s[k] >> 1) + (45'd1 << (42 - 2 * k));
			end else begin
				sq_rem_s[k+1] <= sq_rem_s[k];
				sq_res_s[k+1] <= sq_res_s[k] >> 1;
			end
		end

		addr_s[2] <= sq_addr_s[SQRT_STEPS];
		for (int k = 3; k <= 11; k++) addr_s[k] <= addr_s[k-1];
		dist_s[3] <= dist_c[21:14];
		for (int k = 4; k <= 11; k++) dist_s[k] <= dist_s[k-1];

		// The root is at least 1 << 16, so the distance never goes negative.
		d_s2 <= 22'(sq_res_s[SQRT_STEPS] - 45'd65536);

		// Phase is d * 400000 / 5969026; the reciprocal estimate is low by at
		// most one and gets a single correcting compare.
		pm_s3 <= 47'(d_s2) * 47'(RECIP);
		pn_s3 <= 41'(d_s2) * 41'd400000;
		qe_s4 <= 18'(pm_s3 >> 28);
		pq_s4 <= 41'(18'(pm_s3 >> 28)) * DIVISOR;
		pn_s4 <= pn_s3;
		phase_s5 <= 16'(qe_s4 + 18'(rem_c >= DIVISOR));

		t_s6     <= phase_s5[14] ? 15'(15'd16384 - 15'(phase_s5[13:0])) : 15'(phase_s5[13:0]);
		neg_s[6] <= phase_s5[15];
		for (int k = 7; k <= 10; k++) neg_s[k] <= neg_s[k-1];

		z2_s7 <= 15'((30'(t_s6) * 30'(t_s6)) >> 14);
		t_s7  <= t_s6;
		u_s8  <= 11'((26'(z2_s7) * 26'd1160) >> 14);
		z2_s8 <= z2_s7;
		t_s8  <= t_s7;
		w_s9  <= 14'((29'(z2_s8) * 29'(14'd10512 - 14'(u_s8))) >> 14);
		t_s9  <= t_s8;
		mag_s10  <= 15'((30'(t_s9) * 30'(15'd25736 - 15'(w_s9))) >> 14);
		wave_s11 <= wave_c[21:14];
	end

	assign wr.vld       = vld_s[11];
	assign wr.addr      = addr_s[11];
	assign wr.dist_byte = dist_s[11];
	assign wr.wave      = wave_s11;
	assign done         = done_q;

	a_addr_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		wr.vld && $past(wr.vld) |-> wr.addr == ADDR_W'($past(wr.addr) + 1'b1))
		else $error("table fill addresses out of order");

	a_no_write_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !wr.vld)
		else $error("table write after fill completed");

endmodule

// ===== sim/plasma_pixel_generator_tb.sv =====
// ----------------------------------------------------------------------------
// Plasma pixel generator testbench
// Drives pixel requests with random gaps, stalls the result stream at random,
// and checks every result against a predictor that rebuilds the distance,
// wave and shift tables and applies the roll, key and displacement rules.
// The register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module plasma_pixel_generator_tb;

	typedef enum logic [2:0] {
		REG_OFFSET_ONE,
		REG_OFFSET_TWO,
		REG_OFFSET_THREE,
		REG_OFFSET_FOUR,
		REG_ROLL,
		REG_KEY,
		REG_MODE,
		REG_SPARE
	} reg_index_e;

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_KEY,
		MODE_DISPLACE,
		MODE_SPARE
	} render_mode_e;

	typedef struct packed {
		logic [3:0][14:0] offset;
		logic [7:0]       roll;
		logic [7:0]       key;
		render_mode_e     mode;
	} plasma_setting_t;

	typedef struct packed {
		logic [6:0] y;
		logic [6:0] x;
	} pixel_req_t;

	typedef struct packed {
		logic       use_source;
		logic [6:0] source_column;
		logic [7:0] pixel_index;
	} pixel_result_t;

	localparam int         DRAIN_CYCLES = 8;
	localparam logic [7:0] KEY_MOD_LIMIT = 8'd200;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [14:0] cfg_data      = '0;

	logic [7:0]      dist_tab [ppg_pkg::ROM_DEPTH];
	logic [7:0]      wave_tab [ppg_pkg::ROM_DEPTH];
	int              shift_tab [256];
	plasma_setting_t live_cfg = '0;

	pixel_req_t    pixel_queue [$];
	pixel_result_t result_q [$];

	int n_issued       = 0;
	int n_accepted     = 0;
	int n_results      = 0;
	int n_settings     = 0;
	int error_count    = 0;
	int send_idle_max  = 11;
	int recv_idle_max  = 11;
	int send_wait      = 0;
	int recv_wait      = 0;
	int mode_hits [4]  = '{0, 0, 0, 0};

	plasma_pixel_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Q14 sine of a 16-bit fraction of a turn, by a polynomial on the quarter wave.
	function automatic int q14_sine(input int unsigned phase);
		int unsigned frac, t, sq, corr, poly, amp;
		frac = phase & 32'h3FFF;
		t    = (phase & 32'h4000) ? 32'd16384 - frac : frac;
		sq   = (t * t) >> 14;
		corr = (sq * 32'd1160) >> 14;
		poly = (sq * (32'd10512 - corr)) >> 14;
		amp  = (t * (32'd25736 - poly)) >> 14;
		return (phase & 32'h8000) ? -int'(amp) : int'(amp);
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned root, probe;
		root = 0;
		// The radicand stays below 2^46, so the root fits in 24 bits.
		for (int b = 23; b >= 0; b--) begin
			probe = root | (64'd1 << b);
			if (probe * probe <= v)
				root = probe;
		end
		return root;
	endfunction

	task automatic build_tables();
		longint unsigned col_sq [256];
		longint unsigned row_sq, amp, root, radius;
		int unsigned     turn;
		int              s, m;
		for (int i = 0; i < 256; i++) begin
			s            = q14_sine(i * 256);
			amp          = 64'd150 * 64'(s < 0 ? -s : s);
			col_sq[i]    = amp * amp;
			m            = ((s < 0 ? -s : s) * 16) >> 14;
			shift_tab[i] = (s < 0) ? -m : m;
		end
		for (int y = 0; y < 256; y++) begin
			s      = q14_sine(y * 256 + 16384);
			amp    = 64'd150 * 64'(s < 0 ? -s : s);
			row_sq = amp * amp;
			for (int x = 0; x < 256; x++) begin
				root   = floor_root((64'd1 << 32) + col_sq[x] + row_sq);
				radius = root - 64'd65536;
				// Phase of the distance / 9.5 radians as a fraction of a turn.
				turn = 32'((radius * 64'd400000) / 64'd5969026);
				s    = q14_sine(turn);
				dist_tab[y * 256 + x] = 8'((radius * 64'd5 + 64'd6554) >> 14);
				wave_tab[y * 256 + x] = 8'(((s + 16384) * 90 + 6554) >> 14);
			end
		end
	endtask

	function automatic logic [7:0] plasma_sum(input logic [6:0] x, input logic [6:0] y);
		logic [15:0] base;
		logic [7:0]  acc;
		base = {1'b0, y, 1'b0, x};
		acc  = live_cfg.roll
		     + dist_tab[16'(base + 16'(live_cfg.offset[0]))]
		     + wave_tab[16'(base + 16'(live_cfg.offset[1]))]
		     + wave_tab[16'(base + 16'(live_cfg.offset[2]))]
		     + wave_tab[16'(base + 16'(live_cfg.offset[3]))];
		return acc;
	endfunction

	function automatic pixel_result_t predict_pixel(input logic [6:0] x, input logic [6:0] y);
		pixel_result_t r;
		logic [7:0]    s;
		s = plasma_sum(x, y);
		r = '0;
		case (live_cfg.mode)
			MODE_DISPLACE: begin
				r.use_source    = 1'b1;
				r.source_column = 7'(int'(x) + shift_tab[s]);
			end
			MODE_KEY: begin
				if (live_cfg.key > KEY_MOD_LIMIT)
					r.pixel_index = s % live_cfg.key;
				else
					r.pixel_index = (s == live_cfg.key) ? s ^ 8'd1 : s;
			end
			default: r.pixel_index = s;
		endcase
		return r;
	endfunction

	function automatic logic [14:0] pick_offset();
		case ($urandom_range(0, 5))
			0:       return 15'h0000;
			1:       return 15'h7FFF;
			default: return 15'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] pick_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 7'd127 : 7'd0;
		return 7'($urandom_range(0, 127));
	endfunction

	task automatic add_pixel(input logic [6:0] x, input logic [6:0] y);
		pixel_queue.push_back({y, x});
		n_issued++;
	endtask

	// Queues the first pixel whose sum equals target under the current offsets.
	task automatic add_sum_match(input logic [7:0] target);
		for (int y = 0; y < 128; y++)
			for (int x = 0; x < 128; x++)
				if (plasma_sum(7'(x), 7'(y)) == target) begin
					add_pixel(7'(x), 7'(y));
					return;
				end
	endtask

	task automatic add_corners();
		add_pixel(7'd0, 7'd0);
		add_pixel(7'd127, 7'd127);
		add_pixel(7'd127, 7'd0);
		add_pixel(7'd0, 7'd127);
	endtask

	// Upper data bits of the narrow registers carry noise that must be dropped.
	task automatic apply_setting(input plasma_setting_t want, input bit poke_spare);
		reg_index_e  idx;
		logic [14:0] word;
		@(posedge clk);
		for (int r = 0; r < 8; r++) begin
			idx = reg_index_e'(r);
			if (idx == REG_SPARE && !poke_spare)
				break;
			case (idx)
				REG_ROLL: begin
					word          = {7'($urandom), want.roll};
					live_cfg.roll = want.roll;
				end
				REG_KEY: begin
					word         = {7'($urandom), want.key};
					live_cfg.key = want.key;
				end
				REG_MODE: begin
					word          = {13'($urandom), want.mode};
					live_cfg.mode = want.mode;
				end
				REG_SPARE: word = 15'($urandom);
				default: begin
					word               = want.offset[r];
					live_cfg.offset[r] = want.offset[r];
				end
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= word;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic wait_quiet();
		while (n_accepted != n_issued || result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : feed_pixels
		logic       hold;
		pixel_req_t req;
		if (arst_n) begin
			hold = s_axis_tvalid && !s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				result_q.push_back(predict_pixel(s_axis_tdata[6:0], s_axis_tdata[13:7]));
				mode_hits[live_cfg.mode]++;
				n_accepted++;
			end
			if (!hold) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pixel_queue.size() > 0) begin
					req          = pixel_queue.pop_front();
					s_axis_tdata <= {2'b00, req.y, req.x};
					hold         = 1'b1;
					send_wait    = $urandom_range(0, send_idle_max);
				end
			end
			s_axis_tvalid <= hold;
		end
	end

	always @(posedge clk) begin : check_results
		pixel_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (result_q.size() == 0) begin
					error_count++;
					$display("%0t: result with no request waiting, actual data %h user %b",
					         $time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = result_q.pop_front();
					if (m_axis_tdata[7:0] !== want.pixel_index) begin
						error_count++;
						$display("%0t: pixel_index expected %0d, actual %0d",
						         $time, want.pixel_index, m_axis_tdata[7:0]);
					end
					if (m_axis_tdata[14:8] !== want.source_column) begin
						error_count++;
						$display("%0t: source_column expected %0d, actual %0d",
						         $time, want.source_column, m_axis_tdata[14:8]);
					end
					if (m_axis_tuser !== want.use_source) begin
						error_count++;
						$display("%0t: use_source expected %b, actual %b",
						         $time, want.use_source, m_axis_tuser);
					end
				end
				recv_wait = $urandom_range(0, recv_idle_max);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		plasma_setting_t cfg;
		build_tables();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Corner pixels with zero offsets, then with every offset and the roll at
		// their largest values.
		cfg = '0;
		apply_setting(cfg, 1'b0);
		add_corners();
		wait_quiet();
		cfg.offset = {4{15'h7FFF}};
		cfg.roll   = 8'hFF;
		apply_setting(cfg, 1'b0);
		add_corners();
		wait_quiet();

		// The unused mode code must behave as plain; the write to the index past
		// the register list must change nothing.
		cfg.offset = {15'd256, 15'd12345, 15'd32639, 15'd0};
		cfg.roll   = 8'd17;
		cfg.mode   = MODE_SPARE;
		apply_setting(cfg, 1'b1);
		add_pixel(7'd3, 7'd4);
		add_pixel(7'd100, 7'd120);
		wait_quiet();

		// Colour key: sums equal to the key, with a zero key, keys at and just above the modulo limit, and the top key.
		cfg.mode = MODE_KEY;
		cfg.key  = 8'd0;
		apply_setting(cfg, 1'b0);
		add_sum_match(8'd0);
		add_pixel(7'd1, 7'd1);
		wait_quiet();
		cfg.key = KEY_MOD_LIMIT;
		apply_setting(cfg, 1'b0);
		add_sum_match(KEY_MOD_LIMIT);
		add_sum_match(KEY_MOD_LIMIT + 8'd1);
		add_pixel(7'd127, 7'd127);
		wait_quiet();
		cfg.key = KEY_MOD_LIMIT + 8'd1;
		apply_setting(cfg, 1'b0);
		add_sum_match(KEY_MOD_LIMIT + 8'd1);
		add_sum_match(KEY_MOD_LIMIT);
		add_pixel(7'd64, 7'd64);
		wait_quiet();
		cfg.key = 8'hFF;
		apply_setting(cfg, 1'b0);
		add_sum_match(8'hFF);
		add_sum_match(8'hFE);
		wait_quiet();

		// Displacement at both frame edges, so the column wraps either way.
		cfg.mode = MODE_DISPLACE;
		apply_setting(cfg, 1'b0);
		add_pixel(7'd0, 7'd37);
		add_pixel(7'd127, 7'd37);
		add_pixel(7'd1, 7'd3);
		add_pixel(7'd126, 7'd100);
		wait_quiet();

		for (int p = 0; p < 12; p++) begin
			for (int k = 0; k < 4; k++)
				cfg.offset[k] = pick_offset();
			cfg.roll = 8'($urandom);
			cfg.key  = $urandom_range(0, 1) ? 8'($urandom_range(201, 255))
			                                : 8'($urandom_range(0, 200));
			case (p % 6)
				0, 3:    cfg.mode = MODE_KEY;
				1, 4:    cfg.mode = MODE_DISPLACE;
				2:       cfg.mode = MODE_PLAIN;
				default: cfg.mode = MODE_SPARE;
			endcase
			case (p % 4)
				0: begin send_idle_max = 11; recv_idle_max = 11; end
				1: begin send_idle_max = 0;  recv_idle_max = 0;  end
				2: begin send_idle_max = 11; recv_idle_max = 0;  end
				default: begin send_idle_max = 0; recv_idle_max = 11; end
			endcase
			apply_setting(cfg, p == 5);
			for (int n = 0; n < 50; n++) begin
				// In one phase the sender holds off until the pipeline has drained.
				if (p == 6 && n == 25)
					wait_quiet();
				add_pixel(pick_coord(), pick_coord());
			end
			wait_quiet();
		end

		$display("Checked %0d results for %0d pixel requests under %0d register settings.",
		         n_results, n_accepted, n_settings);
		$display("Requests by mode: plain %0d, colour key %0d, displace %0d, unused code %0d.",
		         mode_hits[MODE_PLAIN], mode_hits[MODE_KEY], mode_hits[MODE_DISPLACE],
		         mode_hits[MODE_SPARE]);
		if (error_count == 0)
			$display("plasma_pixel_generator test passed");
		else
			$display("plasma_pixel_generator test failed");
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("plasma_pixel_generator test failed");
		$finish;
	end

endmodule

// ===== plasma_pixel_generator.f =====
rtl/ppg_pkg.sv
rtl/ppg_table_fill.sv
rtl/plasma_pixel_generator.sv
sim/plasma_pixel_generator_tb.sv
